// File: rtl/spimbc_pkg.sv
// shared types and constants of the spi master byte controller
package spimbc_pkg;

    localparam int BYTE_W     = 8;   // width of write_byte and read_byte
    localparam int PRESC_W    = 8;   // prescaler and tick counter width
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CMD_W      = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CPOL      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CPHA      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IRQ_EN    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PRESCALER = 3'd4;

    // status byte bit positions
    localparam int STAT_READY_BIT = 0;
    localparam int STAT_BUSY_BIT  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    typedef struct packed {
        logic               enable;
        logic               cpol;
        logic               cpha;
        logic               irq_en;
        logic [PRESC_W-1:0] prescaler;
    } cfg_t;

    // polarity write taken while idle, moves sclk to the new idle level
    typedef struct packed {
        logic pol_wr;
        logic pol_val;
    } cfg_evt_t;

    typedef struct packed {
        logic              irq;
        logic              busy;
        logic              ready;
        logic [BYTE_W-1:0] read_byte;
        logic              mosi;
        logic              sclk;
    } res_t;

endpackage

// File: rtl/spi_master_byte_controller_core.sv
// top level of the spi master byte controller, modes 0 to 3, msb first
//
// input channel s_*: one item per command; s_tuser carries the command
// (tick, write transmit word, read receive word, read status), s_tdata the
// transmit byte and the miso level sampled for this tick
// result channel m_*: exactly one item per input item, carrying sclk, mosi,
// the read byte, ready, busy and the end-of-exchange interrupt pulse
// the result of an item is registered and presented in the cycle after it is accepted
// throughput: one item per cycle while results are taken; the state update and the result
// register load happen in the same cycle, so ticks stream at full clock rate
// stall: s_tready drops only while the result register holds an item that
// m_tready has not taken; accepted items are never lost or repeated
// reset (aresetn low, synchronous): exchange idle, sclk low, all config zero
// config: cfg_we writes register cfg_addr (enable, cpol, cpha, irq enable,
// prescaler); cpol/cpha writes are ignored during an exchange
// one spi bit lasts 2*(prescaler+1) tick items
module spi_master_byte_controller_core
    import spimbc_pkg::*;
#(
    parameter int WORD_BITS    = 8,
    parameter int PRESCALE_MAX = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] write_byte, [8] miso_in, rest zero
    input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [0] sclk_out, [1] mosi_out, [9:2] read_byte,
                                             // [10] transfer_ready, [11] busy_res,
                                             // [12] irq_pulse, rest zero
);

    cfg_t     cfg;
    cfg_evt_t evt;
    res_t     res;
    logic     busy;
    logic     accept;
    logic     out_free;
    cmd_t     cmd;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = out_free;
    assign accept   = s_tvalid && out_free;

    // register bank; polarity/phase writes are blocked while an exchange runs
    spimbc_cfg #(
        .PRESCALE_MAX (PRESCALE_MAX)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .busy      (busy),
        .cfg       (cfg),
        .evt       (evt)
    );

    // exchange state, advanced once per accepted item
    spimbc_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd        (cmd),
        .write_byte (s_tdata[BYTE_W-1:0]),
        .miso_in    (s_tdata[BYTE_W]),
        .cfg        (cfg),
        .evt        (evt),
        .busy       (busy),
        .res        (res)
    );

    // result register, loaded with the post-update view of the state
    spimbc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .free     (out_free)
    );

    // an interrupt item always reports a finished, idle exchange
    a_irq_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> m_tdata[10] && !m_tdata[11])
        else $error("irq item without ready or with busy");

    // an exchange only starts on an accepted write item
    a_start_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy) |-> $past(accept && cmd == CMD_WRITE && cfg.enable))
        else $error("exchange started without an accepted write");

    // ready and busy never stand together in a result
    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
        else $error("result shows ready and busy together");

    // every accepted item leaves a result in the register
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

endmodule

// File: rtl/spimbc_cfg.sv
// configuration register bank of the spi master byte controller
module spimbc_cfg
    import spimbc_pkg::*;
#(
    parameter int PRESCALE_MAX = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  busy,
    output cfg_t                  cfg,
    output cfg_evt_t              evt
);

    cfg_t cfg_reg, cfg_next;
    logic [PRESC_W-1:0] presc_sat;

    // clamp the prescaler to the supported maximum
    always_comb begin
        if (32'(cfg_wdata) > PRESCALE_MAX) begin
            presc_sat = PRESC_W'(PRESCALE_MAX);
        end else begin
            presc_sat = PRESC_W'(cfg_wdata);
        end
    end

    always_comb begin
        cfg_next    = cfg_reg;
        evt.pol_wr  = 1'b0;
        evt.pol_val = cfg_wdata[0];
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_ENABLE: begin
                    cfg_next.enable = cfg_wdata[0];
                end
                REG_CPOL: begin
                    if (!busy) begin
                        cfg_next.cpol = cfg_wdata[0];
                        evt.pol_wr    = 1'b1;
                    end
                end
                REG_CPHA: begin
                    if (!busy) cfg_next.cpha = cfg_wdata[0];
                end
                REG_IRQ_EN: begin
                    cfg_next.irq_en = cfg_wdata[0];
                end
                REG_PRESCALER: begin
                    cfg_next.prescaler = presc_sat;
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/spimbc_core.sv
// bit timing, shifter and status state of the spi master byte controller
module spimbc_core
    import spimbc_pkg::*;
#(
    parameter int WORD_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  cmd_t              cmd,
    input  logic [BYTE_W-1:0] write_byte,
    input  logic              miso_in,
    input  cfg_t              cfg,
    input  cfg_evt_t          evt,
    output logic              busy,
    output res_t              res
);

    localparam int BCNT_W = $clog2(WORD_BITS);
    localparam logic [BCNT_W-1:0] LAST_BIT = BCNT_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [WORD_BITS-1:0] hold_reg, hold_next;
    logic [BCNT_W-1:0]    bcnt_reg, bcnt_next;
    logic [PRESC_W-1:0]   tick_reg, tick_next;
    logic                 sclk_reg, sclk_next;
    logic                 half_reg, half_next;
    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic                 leading;
    logic                 irq;
    logic [BYTE_W-1:0]    rd;

    assign leading = (sclk_reg == cfg.cpol);

    always_comb begin
        shift_next  = shift_reg;
        hold_next   = hold_reg;
        bcnt_next   = bcnt_reg;
        tick_next   = tick_reg;
        sclk_next   = sclk_reg;
        half_next   = half_reg;
        active_next = active_reg;
        done_next   = done_reg;
        irq         = 1'b0;
        rd          = '0;
        if (accept) begin
            unique case (cmd)
                CMD_TICK: begin
                    if (active_reg) begin
                        if (tick_reg >= cfg.prescaler) begin
                            tick_next = '0;
                            sclk_next = ~sclk_reg;
                            if (leading) begin
                                if (!cfg.cpha) begin
                                    half_next = miso_in;
                                end else if (bcnt_reg != '0) begin
                                    shift_next = {shift_reg[WORD_BITS-2:0], half_reg};
                                end
                            end else begin
                                if (!cfg.cpha) begin
                                    shift_next = {shift_reg[WORD_BITS-2:0], half_reg};
                                end else begin
                                    half_next = miso_in;
                                    if (bcnt_reg == LAST_BIT) begin
                                        shift_next = {shift_reg[WORD_BITS-2:0], miso_in};
                                    end
                                end
                                bcnt_next = bcnt_reg + 1'b1;
                                // trailing edge of the last bit ends the exchange
                                if (bcnt_reg == LAST_BIT) begin
                                    hold_next   = shift_next;
                                    active_next = 1'b0;
                                    done_next   = 1'b1;
                                    bcnt_next   = '0;
                                    sclk_next   = cfg.cpol;
                                    irq         = cfg.irq_en;
                                end
                            end
                        end else begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                CMD_WRITE: begin
                    if (cfg.enable && !active_reg) begin
                        shift_next  = WORD_BITS'(write_byte);
                        bcnt_next   = '0;
                        tick_next   = '0;
                        half_next   = 1'b0;
                        sclk_next   = cfg.cpol;
                        active_next = 1'b1;
                        done_next   = 1'b0;
                    end
                end
                CMD_READ: begin
                    rd = BYTE_W'(hold_reg);
                end
                CMD_STATUS: begin
                    rd[STAT_READY_BIT] = done_reg;
                    rd[STAT_BUSY_BIT]  = active_reg;
                end
                default: begin
                    rd = '0;
                end
            endcase
        end
        if (evt.pol_wr) sclk_next = evt.pol_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            hold_reg   <= '0;
            bcnt_reg   <= '0;
            tick_reg   <= '0;
            sclk_reg   <= 1'b0;
            half_reg   <= 1'b0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            shift_reg  <= shift_next;
            hold_reg   <= hold_next;
            bcnt_reg   <= bcnt_next;
            tick_reg   <= tick_next;
            sclk_reg   <= sclk_next;
            half_reg   <= half_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    assign busy          = active_reg;
    assign res.sclk      = sclk_next;
    assign res.mosi      = active_next & shift_next[WORD_BITS-1];
    assign res.read_byte = rd;
    assign res.ready     = done_next;
    assign res.busy      = active_next;
    assign res.irq       = irq;

endmodule

// File: rtl/spimbc_out.sv
// result register of the spi master byte controller
module spimbc_out
    import spimbc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  res_t                 res,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 free
);

    localparam int PAD_W = M_TDATA_W - $bits(res_t);

    logic valid_reg, valid_next;
    res_t data_reg;

    // the register is free when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) data_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, data_reg};

endmodule
